// ===== rtl/tocw_pkg.sv =====
// Shared types and constants of the time-of-day crossfade weight block.
// Depends on nothing; tocw_front and the top level refer to it by scoped names.
package tocw_pkg;

    localparam int IN_W       = 32;
    localparam int OUT_W      = 16;
    localparam int LANES      = 4;
    localparam int DEN_SCALE  = 35;
    localparam int EPS_INV    = 1000000;
    localparam int FULL_HOURS = 24;

    // Lane order: dawn, day, dusk, night.
    localparam int PEAK_HOURS [LANES] = '{6, 13, 20, 1};
    localparam int HALF_HOURS [LANES] = '{7, 7, 7, 5};

    typedef logic [IN_W-1:0]  hour_t;
    typedef logic [OUT_W-1:0] weight_t;

endpackage

// ===== rtl/tocw_front.sv =====
// Front end of the crossfade weight pipeline: wrap the hour into a day, fold the
// distances, form the triangle numerators and pick the divisor. Uses tocw_pkg.
module tocw_front #(
    parameter int HOUR_FRAC_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  tocw_pkg::hour_t            hour_fixed,
    output logic                       out_valid,
    output logic [HOUR_FRAC_BITS+5:0]  num [tocw_pkg::LANES],
    output logic [HOUR_FRAC_BITS+7:0]  den
);

    localparam int F  = HOUR_FRAC_BITS;
    localparam int QW = tocw_pkg::IN_W - F - 3;
    localparam int ND = (QW + 1) / 2;
    localparam int HW = F + 5;
    localparam int NW = F + 6;
    localparam int DW = F + 8;
    localparam logic [1:0]    WRAP3 = (QW % 2 == 0) ? 2'd1 : 2'd2;
    localparam logic [HW-1:0] FULL  = HW'(tocw_pkg::FULL_HOURS) << F;
    localparam logic [DW-1:0] DEN0  = DW'(tocw_pkg::DEN_SCALE) << F;
    localparam logic [DW-1:0] THR   =
        DW'((longint'(tocw_pkg::DEN_SCALE) << F) / tocw_pkg::EPS_INV);

    logic          v1_reg, v2_reg, v3_reg, v4_reg;
    logic [HW-1:0] h_reg, h_next;
    logic [HW-1:0] d_reg [tocw_pkg::LANES];
    logic [HW-1:0] d_next [tocw_pkg::LANES];
    logic [NW-1:0] n_reg [tocw_pkg::LANES];
    logic [NW-1:0] n_next [tocw_pkg::LANES];
    logic [NW-1:0] n4_reg [tocw_pkg::LANES];
    logic [DW-1:0] den_reg, den_next;

    // The hour splits into a multiple of 8 units and a low part below that;
    // 24 units is 3 * 8, so only the upper part needs a reduction modulo 3.
    always_comb
    begin
        logic [2*ND-1:0] q_pad;
        logic [5:0]      dsum;
        logic [3:0]      t;
        logic [1:0]      c;
        logic [2:0]      m3;
        q_pad = (2*ND)'(hour_fixed[tocw_pkg::IN_W-1:F+3]);
        dsum  = '0;
        for (int i = 0; i < ND; i++)
        begin
            dsum = dsum + 6'(q_pad[2*i +: 2]);
        end
        t = 4'(dsum[1:0]) + 4'(dsum[3:2]) + 4'(dsum[5:4]);
        if (t >= 4'd6)
        begin
            t = t - 4'd6;
        end
        if (t >= 4'd3)
        begin
            t = t - 4'd3;
        end
        c  = hour_fixed[tocw_pkg::IN_W-1] ? WRAP3 : 2'd0;
        m3 = 3'(t[1:0]) + 3'd3 - 3'(c);
        if (m3 >= 3'd3)
        begin
            m3 = m3 - 3'd3;
        end
        h_next = {m3[1:0], hour_fixed[F+2:0]};
    end

    // Distance to each peak, taken the shorter way round the clock.
    always_comb
    begin
        logic [HW-1:0] pk, diff, alt;
        for (int l = 0; l < tocw_pkg::LANES; l++)
        begin
            pk   = HW'(tocw_pkg::PEAK_HOURS[l]) << F;
            diff = (h_reg >= pk) ? h_reg - pk : pk - h_reg;
            alt  = FULL - diff;
            d_next[l] = (alt < diff) ? alt : diff;
        end
    end

    // Numerators share the denominator 35 units.
    always_comb
    begin
        logic [HW-1:0] hwu;
        for (int l = 0; l < tocw_pkg::LANES; l++)
        begin
            hwu = HW'(tocw_pkg::HALF_HOURS[l]) << F;
            if (d_reg[l] < hwu)
            begin
                n_next[l] = NW'(hwu - d_reg[l])
                    * NW'(tocw_pkg::DEN_SCALE / tocw_pkg::HALF_HOURS[l]);
            end
            else
            begin
                n_next[l] = '0;
            end
        end
    end

    always_comb
    begin
        logic [DW-1:0] sum;
        sum = DW'(n_reg[0]) + DW'(n_reg[1]) + DW'(n_reg[2]) + DW'(n_reg[3]);
        den_next = (sum > THR) ? sum : DEN0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg   <= h_next;
        d_reg   <= d_next;
        n_reg   <= n_next;
        n4_reg  <= n_reg;
        den_reg <= den_next;
    end

    assign out_valid = v4_reg;
    assign num       = n4_reg;
    assign den       = den_reg;

endmodule

// ===== rtl/tocw_div.sv =====
// One lane of the pipelined restoring divider: rounded quotient of num * 2^WF
// by den, one quotient bit per register stage. Uses no package items.
module tocw_div #(
    parameter int NW = 22,
    parameter int DW = 24,
    parameter int WF = 15
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          out_valid,
    output logic [WF:0]   quo
);

    localparam int QB = WF + 1;
    localparam int XW = NW + WF + 1;

    logic [QB:0]   v_reg;
    logic [DW-1:0] rem_reg [0:QB];
    logic [DW-1:0] rem_next [0:QB];
    logic [DW-1:0] den_reg [0:QB];
    logic [QB-1:0] low_reg [0:QB];
    logic [QB-1:0] low_next [0:QB];
    logic [QB-1:0] q_reg [0:QB];
    logic [QB-1:0] q_next [0:QB];

    // The partial remainder starts below den because the quotient fits QB bits.
    always_comb
    begin
        logic [XW-1:0] x;
        logic [DW:0]   t;
        x = (XW'(num) << WF) + XW'(den >> 1);
        rem_next[0] = DW'(x[XW-1:QB]);
        low_next[0] = x[QB-1:0];
        q_next[0]   = '0;
        for (int k = 1; k <= QB; k++)
        begin
            t = {rem_reg[k-1], low_reg[k-1][QB-1]};
            if (t >= (DW+1)'(den_reg[k-1]))
            begin
                rem_next[k] = DW'(t - (DW+1)'(den_reg[k-1]));
                q_next[k]   = {q_reg[k-1][QB-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = DW'(t);
                q_next[k]   = {q_reg[k-1][QB-2:0], 1'b0};
            end
            low_next[k] = {low_reg[k-1][QB-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[QB-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        low_reg    <= low_next;
        q_reg      <= q_next;
        den_reg[0] <= den;
        for (int k = 1; k <= QB; k++)
        begin
            den_reg[k] <= den_reg[k-1];
        end
    end

    assign out_valid = v_reg[QB];
    assign quo       = q_reg[QB];

endmodule

// ===== rtl/time_of_day_crossfade_weights.sv =====
// Top level of the time-of-day crossfade weight block: front end plus four
// divider lanes. Uses tocw_pkg, tocw_front and tocw_div.
//
// Usage: drive hour_fixed (signed, HOUR_FRAC_BITS fraction bits) and raise
// start for one cycle per request. busy is always low, so a request is taken
// at every rising edge where start is high, one per cycle if wanted.
// Each request yields one result: dawn_weight, day_weight, dusk_weight and
// night_weight (WEIGHT_FRAC_BITS fraction bits) are shown for exactly one
// cycle with done high.
// Pipeline: four front-end stages, one divider setup stage and one stage per
// quotient bit in the divider lanes; the first front-end stage loads at the
// accepting edge.
// Throughput: one request per cycle; results leave in request order.
// Reset clears every valid bit, so no stray done appears after reset.
// The receiver cannot stall; it must take each result in its done cycle.
module time_of_day_crossfade_weights #(
    parameter int HOUR_FRAC_BITS   = 16,
    parameter int WEIGHT_FRAC_BITS = 15
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tocw_pkg::hour_t   hour_fixed,
    output logic              done,
    output tocw_pkg::weight_t dawn_weight,
    output tocw_pkg::weight_t day_weight,
    output tocw_pkg::weight_t dusk_weight,
    output tocw_pkg::weight_t night_weight
);

    localparam int NW = HOUR_FRAC_BITS + 6;
    localparam int DW = HOUR_FRAC_BITS + 8;

    logic                    front_valid;
    logic [NW-1:0]           num [tocw_pkg::LANES];
    logic [DW-1:0]           den;
    logic [tocw_pkg::LANES-1:0] lane_valid;
    logic [WEIGHT_FRAC_BITS:0]  quo [tocw_pkg::LANES];

    assign busy = 1'b0;

    tocw_front #(
        .HOUR_FRAC_BITS(HOUR_FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .hour_fixed(hour_fixed),
        .out_valid (front_valid),
        .num       (num),
        .den       (den)
    );

    for (genvar l = 0; l < tocw_pkg::LANES; l++)
    begin : g_lane
        tocw_div #(
            .NW(NW),
            .DW(DW),
            .WF(WEIGHT_FRAC_BITS)
        ) u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (front_valid),
            .num      (num[l]),
            .den      (den),
            .out_valid(lane_valid[l]),
            .quo      (quo[l])
        );
    end

    // All lanes run in lockstep; the valid bits agree.
    assign done         = &lane_valid;
    assign dawn_weight  = tocw_pkg::OUT_W'(quo[0]);
    assign day_weight   = tocw_pkg::OUT_W'(quo[1]);
    assign dusk_weight  = tocw_pkg::OUT_W'(quo[2]);
    assign night_weight = tocw_pkg::OUT_W'(quo[3]);

endmodule
